// ===== hdl/pfde_pkg.sv =====
// shared types, constants and helpers for the playfair digraph encrypter
package pfde_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned Alphabet = 26;
  localparam int unsigned Cells = 25;
  localparam int unsigned Side = 5;

  localparam logic [LetterW-1:0] LetterI = 5'd8;
  localparam logic [LetterW-1:0] LetterJ = 5'd9;
  localparam logic [LetterW-1:0] LetterX = 5'd23;
  localparam logic [LetterW-1:0] LetterZ = 5'd25;
  localparam logic [LetterW-1:0] CellsCode = 5'd25;
  localparam logic [LetterW-1:0] AlphabetCode = 5'd26;

  localparam logic ModeKey = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [LetterW-1:0] letter;
    logic               last;
  } pfde_in_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_letter;
    logic               end_of_message;
  } pfde_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic place_key;
    logic walk_step;
    logic route;
    logic cap_pa;
    logic calc;
    logic cap_c0;
    logic cap_c1;
    logic load_out0;
    logic load_out1;
  } pfde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic key_ok;
    logic walk_done;
    logic complete;
    logic holding;
    logic last;
    logic out_free;
  } pfde_sts_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pfde_rc_t;

  // cell index to row and column, row by reciprocal multiply (exact below 25)
  function automatic pfde_rc_t cell_rc(input logic [LetterW-1:0] p);
    logic [LetterW-1:0] q;
    logic [8:0]         prod;
    logic [LetterW-1:0] base;
    pfde_rc_t           rc;
    q    = (p >= CellsCode) ? p - CellsCode : p;
    prod = {4'd0, q} * 9'd13;
    rc.row = prod[8:6];
    base = {2'd0, rc.row} * 5'd5;
    rc.col = 3'(q - base);
    return rc;
  endfunction

  function automatic logic [LetterW-1:0] rc_cell(input logic [2:0] row, input logic [2:0] col);
    logic [LetterW-1:0] base;
    base = {2'd0, row} * 5'd5;
    return base + {2'd0, col};
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'(Side - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

// ===== hdl/pfde_ram.sv =====
// generic single write port, single read port ram with registered read
module pfde_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pfde_ctrl.sv =====
// sequencing state machine for key fill, square completion and pair encryption
module pfde_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfde_pkg::pfde_sts_t sts_i,
  output pfde_pkg::pfde_cmd_t cmd_o
);
  import pfde_pkg::*;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StDispatch = 4'd1;
  localparam logic [3:0] StWalk     = 4'd2;
  localparam logic [3:0] StRoute    = 4'd3;
  localparam logic [3:0] StRdPa     = 4'd4;
  localparam logic [3:0] StRdPb     = 4'd5;
  localparam logic [3:0] StCalc     = 4'd6;
  localparam logic [3:0] StRdA      = 4'd7;
  localparam logic [3:0] StRdB      = 4'd8;
  localparam logic [3:0] StCapB     = 4'd9;
  localparam logic [3:0] StOut0     = 4'd10;
  localparam logic [3:0] StOut1     = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StDispatch;
        end
      end
      StDispatch: begin
        if (sts_i.mode == ModeKey) begin
          cmd_o.place_key = sts_i.key_ok;
          state_d = StIdle;
        end else if (!sts_i.complete) begin
          state_d = StWalk;
        end else begin
          state_d = StRoute;
        end
      end
      StWalk: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = StRoute;
        end
      end
      StRoute: begin
        cmd_o.route = 1'b1;
        state_d = (sts_i.holding || sts_i.last) ? StRdPa : StIdle;
      end
      StRdPa: state_d = StRdPb;
      StRdPb: begin
        cmd_o.cap_pa = 1'b1;
        state_d = StCalc;
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d = StRdA;
      end
      StRdA: state_d = StRdB;
      StRdB: begin
        cmd_o.cap_c0 = 1'b1;
        state_d = StCapB;
      end
      StCapB: begin
        cmd_o.cap_c1 = 1'b1;
        state_d = StOut0;
      end
      StOut0: begin
        if (sts_i.out_free) begin
          cmd_o.load_out0 = 1'b1;
          state_d = StOut1;
        end
      end
      StOut1: begin
        if (sts_i.out_free) begin
          cmd_o.load_out1 = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/pfde_dp.sv =====
// datapath: square and position memories, letter marks, pair math, output register
module pfde_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfde_pkg::pfde_in_t  in_data_i,
  input  pfde_pkg::pfde_cmd_t cmd_i,
  output pfde_pkg::pfde_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfde_pkg::pfde_out_t out_data_o
);
  import pfde_pkg::*;

  pfde_in_t           item_q;
  logic [Alphabet-1:0] used_q;
  logic [LetterW-1:0] fill_q;
  logic               complete_q;
  logic [LetterW-1:0] walk_q;
  logic [LetterW-1:0] held_q;
  logic               holding_q;
  logic [LetterW-1:0] a_q, b_q;
  logic               end_q;
  logic [LetterW-1:0] pa_q;
  logic [LetterW-1:0] ea_q, eb_q;
  logic [LetterW-1:0] c0_q, c1_q;
  logic               out_valid_q;
  pfde_out_t          out_q;

  logic               room;
  logic               key_ok;
  logic               walk_ok;
  logic               place_en;
  logic [LetterW-1:0] place_letter;
  logic [LetterW-1:0] msg_letter;
  logic [LetterW-1:0] pos_raddr, pos_rdata;
  logic [LetterW-1:0] sq_raddr, sq_rdata;
  pfde_rc_t           rc_a, rc_b;
  logic [LetterW-1:0] ea_d, eb_d;

  assign room    = (fill_q < CellsCode);
  assign key_ok  = !complete_q && (item_q.letter < AlphabetCode) &&
                   !used_q[item_q.letter] && room;
  assign walk_ok = !used_q[walk_q] && room;

  assign place_en     = (cmd_i.place_key) || (cmd_i.walk_step && walk_ok);
  assign place_letter = cmd_i.walk_step ? walk_q : item_q.letter;

  // clamp out of range to z, fold j into i
  always_comb begin
    msg_letter = item_q.letter;
    if (msg_letter > LetterZ) begin
      msg_letter = LetterZ;
    end
    if (msg_letter == LetterJ) begin
      msg_letter = LetterI;
    end
  end

  assign pos_raddr = cmd_i.cap_pa ? b_q : a_q;
  assign sq_raddr  = cmd_i.cap_c0 ? eb_q : ea_q;

  pfde_ram #(
    .Width(LetterW),
    .Depth(Cells)
  ) u_square (
    .clk_i,
    .we_i   (place_en),
    .waddr_i(fill_q),
    .wdata_i(place_letter),
    .raddr_i(sq_raddr),
    .rdata_o(sq_rdata)
  );

  pfde_ram #(
    .Width(LetterW),
    .Depth(Alphabet)
  ) u_position (
    .clk_i,
    .we_i   (place_en),
    .waddr_i(place_letter),
    .wdata_i(fill_q),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  // same row shifts right, same column shifts down, else rectangle corners
  always_comb begin
    rc_a = cell_rc(pa_q);
    rc_b = cell_rc(pos_rdata);
    if (rc_a.row == rc_b.row) begin
      ea_d = rc_cell(rc_a.row, wrap_inc(rc_a.col));
      eb_d = rc_cell(rc_b.row, wrap_inc(rc_b.col));
    end else if (rc_a.col == rc_b.col) begin
      ea_d = rc_cell(wrap_inc(rc_a.row), rc_a.col);
      eb_d = rc_cell(wrap_inc(rc_b.row), rc_b.col);
    end else begin
      ea_d = rc_cell(rc_a.row, rc_b.col);
      eb_d = rc_cell(rc_b.row, rc_a.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= Alphabet'(1) << LetterJ;
      fill_q      <= '0;
      complete_q  <= 1'b0;
      walk_q      <= '0;
      held_q      <= '0;
      holding_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        walk_q <= '0;
      end
      if (place_en) begin
        used_q[place_letter] <= 1'b1;
        fill_q <= fill_q + 5'd1;
      end
      if (cmd_i.walk_step) begin
        walk_q <= walk_q + 5'd1;
        if (walk_q == LetterZ) begin
          complete_q <= 1'b1;
        end
      end
      if (cmd_i.route) begin
        if (holding_q) begin
          holding_q <= 1'b0;
          held_q    <= '0;
        end else if (!item_q.last) begin
          holding_q <= 1'b1;
          held_q    <= msg_letter;
        end
      end
      if (cmd_i.load_out0 || cmd_i.load_out1) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.route) begin
      if (holding_q) begin
        a_q   <= held_q;
        b_q   <= msg_letter;
        end_q <= item_q.last;
      end else begin
        a_q   <= msg_letter;
        b_q   <= LetterX;
        end_q <= 1'b1;
      end
    end
    if (cmd_i.cap_pa) begin
      pa_q <= pos_rdata;
    end
    if (cmd_i.calc) begin
      ea_q <= ea_d;
      eb_q <= eb_d;
    end
    if (cmd_i.cap_c0) begin
      c0_q <= sq_rdata;
    end
    if (cmd_i.cap_c1) begin
      c1_q <= sq_rdata;
    end
    if (cmd_i.load_out0) begin
      out_q.cipher_letter  <= c0_q;
      out_q.end_of_message <= 1'b0;
    end else if (cmd_i.load_out1) begin
      out_q.cipher_letter  <= c1_q;
      out_q.end_of_message <= end_q;
    end
  end

  assign sts_o.mode      = item_q.mode;
  assign sts_o.key_ok    = key_ok;
  assign sts_o.walk_done = (walk_q == LetterZ);
  assign sts_o.complete  = complete_q;
  assign sts_o.holding   = holding_q;
  assign sts_o.last      = item_q.last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/playfair_digraph_encrypt.sv =====
// top level of the playfair digraph encrypter
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o   pfde_in_t  {mode, letter, last}
//   out       output     out_valid_o/out_ready_i pfde_out_t {cipher_letter, end_of_message}
//
// a key letter is placed in the dispatch state before the next one can be taken
// the first message letter adds a walk over the alphabet that fills the rest of
//   the square; the walk is one letter a cycle against the single write port of each memory
// a held message letter passes only dispatch and route; a letter that closes a pair then goes
//   through four registered reads (two positions, then two square cells)
// reset clears the control state; square and position memories hold garbage until written
// a stalled output holds at most one cipher letter; the sequencer waits only when that
//   register is still full, and input is taken again as soon as the second letter is loaded
module playfair_digraph_encrypt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfde_pkg::pfde_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfde_pkg::pfde_out_t out_data_o
);
  import pfde_pkg::*;

  // commands down, status up
  pfde_cmd_t cmd;
  pfde_sts_t sts;

  // sequencer: one input transfer in flight at a time
  pfde_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  // storage, letter math and the output register
  pfde_dp u_dp (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .cmd_i(cmd),
    .sts_o(sts),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule
